FILE: rtl/sfr_pkg.sv
// Shared types, constants and the CRC-8 byte update for the serial frame receiver.
// No dependencies.
package sfr_pkg;

   // Frame framing bytes, check polynomial and minimum frame length
   localparam logic [7:0] SYNC_FIRST  = 8'h55;
   localparam logic [7:0] SYNC_SECOND = 8'hAA;
   localparam logic [7:0] TAIL_FIRST  = 8'h0D;
   localparam logic [7:0] TAIL_SECOND = 8'h0A;
   localparam logic [7:0] CRC_POLY    = 8'h8C;
   localparam logic [7:0] MIN_LENGTH  = 8'd7;

   // Fixed frame positions before the payload
   localparam logic [7:0] POS_HUNT    = 8'd0;
   localparam logic [7:0] POS_SYNC2   = 8'd1;
   localparam logic [7:0] POS_LENGTH  = 8'd2;
   localparam logic [7:0] POS_CODE    = 8'd3;
   localparam logic [7:0] POS_PAYLOAD = 8'd4;

   // Result words and the kept payload head
   localparam int WORDS_OUT  = 3;
   localparam int HEAD_DEPTH = 2 * WORDS_OUT;

   typedef logic [WORDS_OUT-1:0][15:0] word_vec_type;

   typedef struct packed {
      logic [7:0]   message_code;
      logic [7:0]   frame_length;
      word_vec_type words;
   } result_type;

   // Reflected CRC-8 update of one byte, LSB first
   function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] v;
      v = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (v[0]) begin
            v = (v >> 1) ^ CRC_POLY;
         end else begin
            v = v >> 1;
         end
      end
      return v;
   endfunction

endpackage

FILE: rtl/serial_frame_receiver_crc8_unit.sv
// Serial frame receiver: hunts for frames, checks CRC-8 and tail, emits one result per good frame.
// Depends on sfr_pkg for constants, result type and the CRC byte update.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | req_rx_byte
//  rsp     | out       | rsp_valid/rsp_stall | code, length, three signed words
//
// One byte is taken per cycle while req is not stalled; the CRC update and position compare finish in that cycle.
// The result of the final tail byte is registered into the result register, or the skid register if a result is held.
// A two-entry output (result register plus skid register) lets req continue while a
// result waits; req stalls only when both entries are full.
// Reset clears the frame position, the output valids and the running state.
module serial_frame_receiver_crc8_unit
   import sfr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_message_code,
   output logic [7:0]         rsp_frame_length,
   output logic signed [15:0] rsp_first_word,
   output logic signed [15:0] rsp_second_word,
   output logic signed [15:0] rsp_third_word
);

   logic [7:0] byte_position_ff, byte_position_in;
   logic [7:0] length_byte_ff, length_byte_in;
   logic [7:0] code_byte_ff, code_byte_in;
   logic [7:0] running_crc_ff, running_crc_in;
   logic [HEAD_DEPTH-1:0][7:0] payload_head_ff, payload_head_in;

   result_type result_ff, result_in;
   result_type skid_ff, skid_in;
   logic       result_valid_ff, result_valid_in;
   logic       skid_valid_ff, skid_valid_in;

   logic       accept;
   logic       new_valid;
   result_type new_result;
   logic [7:0] crc_next;
   logic [7:0] head_index;
   logic [7:0] len_minus3, len_minus2, len_minus1;
   logic       pop;

   assign accept    = req_valid && !req_stall;
   assign req_stall = skid_valid_ff;
   assign pop       = result_valid_ff && !rsp_stall;

   assign crc_next   = crc_update(running_crc_ff, req_rx_byte);
   assign head_index = byte_position_ff - POS_PAYLOAD;
   assign len_minus3 = length_byte_ff - 8'd3;
   assign len_minus2 = length_byte_ff - 8'd2;
   assign len_minus1 = length_byte_ff - 8'd1;

   // Advance the frame position and running state for each byte taken
   always_comb begin
      byte_position_in = byte_position_ff;
      length_byte_in   = length_byte_ff;
      code_byte_in     = code_byte_ff;
      running_crc_in   = running_crc_ff;
      payload_head_in  = payload_head_ff;
      new_valid        = 1'b0;
      if (accept) begin
         priority if (byte_position_ff == POS_HUNT) begin
            if (req_rx_byte == SYNC_FIRST) begin
               running_crc_in   = crc_update(8'd0, req_rx_byte);
               byte_position_in = POS_SYNC2;
            end
         end else if (byte_position_ff == POS_SYNC2) begin
            // a wrong second sync byte is not retried as a first one
            if (req_rx_byte == SYNC_SECOND) begin
               running_crc_in   = crc_next;
               byte_position_in = POS_LENGTH;
            end else begin
               byte_position_in = POS_HUNT;
            end
         end else if (byte_position_ff == POS_LENGTH) begin
            length_byte_in = req_rx_byte;
            if (req_rx_byte < MIN_LENGTH) begin
               byte_position_in = POS_HUNT;
            end else begin
               running_crc_in   = crc_next;
               byte_position_in = POS_CODE;
            end
         end else if (byte_position_ff == POS_CODE) begin
            code_byte_in     = req_rx_byte;
            running_crc_in   = crc_next;
            byte_position_in = POS_PAYLOAD;
         end else if (byte_position_ff < len_minus3) begin
            // payload: keep the head, fold every byte into the CRC
            for (int k = 0; k < HEAD_DEPTH; k++) begin
               if (head_index == 8'(k)) begin
                  payload_head_in[k] = req_rx_byte;
               end
            end
            running_crc_in   = crc_next;
            byte_position_in = byte_position_ff + 8'd1;
         end else if (byte_position_ff == len_minus3) begin
            byte_position_in = (req_rx_byte == running_crc_ff) ?
                               byte_position_ff + 8'd1 : POS_HUNT;
         end else if (byte_position_ff == len_minus2) begin
            byte_position_in = (req_rx_byte == TAIL_FIRST) ?
                               byte_position_ff + 8'd1 : POS_HUNT;
         end else begin
            new_valid        = (byte_position_ff == len_minus1) &&
                               (req_rx_byte == TAIL_SECOND);
            byte_position_in = POS_HUNT;
         end
      end
   end

   // Build the result; words past the payload read as zero
   always_comb begin
      new_result.message_code = code_byte_ff;
      new_result.frame_length = length_byte_ff;
      for (int i = 0; i < WORDS_OUT; i++) begin
         if (9'(2 * i + 9) <= {1'b0, length_byte_ff}) begin
            new_result.words[i] = {payload_head_ff[2*i+1], payload_head_ff[2*i]};
         end else begin
            new_result.words[i] = 16'd0;
         end
      end
   end

   // Output register with skid: drain skid first, park a new result if the output holds
   always_comb begin
      result_in       = result_ff;
      result_valid_in = result_valid_ff;
      skid_in         = skid_ff;
      skid_valid_in   = skid_valid_ff;
      if (!result_valid_ff || pop) begin
         if (skid_valid_ff) begin
            result_in       = skid_ff;
            result_valid_in = 1'b1;
            skid_valid_in   = 1'b0;
         end else begin
            result_in       = new_result;
            result_valid_in = new_valid;
         end
      end else if (new_valid) begin
         skid_in       = new_result;
         skid_valid_in = 1'b1;
      end
   end

   // Hold state and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= POS_HUNT;
         length_byte_ff   <= 8'd0;
         code_byte_ff     <= 8'd0;
         running_crc_ff   <= 8'd0;
         payload_head_ff  <= '0;
         result_valid_ff  <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         byte_position_ff <= byte_position_in;
         length_byte_ff   <= length_byte_in;
         code_byte_ff     <= code_byte_in;
         running_crc_ff   <= running_crc_in;
         payload_head_ff  <= payload_head_in;
         result_valid_ff  <= result_valid_in;
         skid_valid_ff    <= skid_valid_in;
      end
      result_ff <= result_in;
      skid_ff   <= skid_in;
   end

   assign rsp_valid        = result_valid_ff;
   assign rsp_message_code = result_ff.message_code;
   assign rsp_frame_length = result_ff.frame_length;
   assign rsp_first_word   = result_ff.words[0];
   assign rsp_second_word  = result_ff.words[1];
   assign rsp_third_word   = result_ff.words[2];

   // The skid entry is only ever filled behind a held result
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> result_valid_ff)
      else $error("skid entry valid without a held result");

   // A fresh result follows a taken second tail byte
   assert property (@(posedge clock) disable iff (reset)
      $rose(result_valid_ff) |->
         $past(req_valid && !req_stall && req_rx_byte == TAIL_SECOND))
      else $error("result raised without a tail byte");

   // From the hunt the position only reaches the second sync slot
   assert property (@(posedge clock) disable iff (reset)
      (byte_position_ff == POS_HUNT) |=>
         (byte_position_ff == POS_HUNT || byte_position_ff == POS_SYNC2))
      else $error("position jumped out of the hunt");

endmodule
